[design/arith_encoder_static_32_unit_macros.svh]
// Assertion macros shared by the arithmetic encoder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ARITH_ENCODER_STATIC_32_UNIT_MACROS_SVH
`define ARITH_ENCODER_STATIC_32_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define AE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/aes32_pkg.sv]
// Package for the static-model arithmetic encoder: operation codes, FSM states.
// No dependencies.
`default_nettype none
package aes32_pkg;
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_DIV0,
    ST_DIV1,
    ST_RENORM,
    ST_OUT,
    ST_FLUSH
  } state_t;
endpackage
`default_nettype wire

[design/aes32_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module aes32_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write-first is not needed; read returns old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[design/aes32_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none
module aes32_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W+1:0] trial;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, q_r[NUM_W-1]} - {2'b00, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DEN_W+1]) begin
        rem_nxt = trial[DEN_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  // quotient of the final step, valid while done is high
  assign done = busy_r && (cnt_r == CW'(1));
  assign quot = {q_r[NUM_W-2:0], !trial[DEN_W+1]};
endmodule
`default_nettype wire

[design/arith_encoder_static_32_unit.sv]
// Top level of the static-model 32-bit arithmetic encoder.
// Depends on aes32_pkg, aes32_ram, aes32_div and the assertion macro header.
//
//  port group | dir | contents
//  in_*       | in  | tuser: operation[1:0]; tdata: symbol[8:0], cum_entry[24:9]
//  out_*      | out | tdata: lead_bit[0], follow_count[32:1]; tlast: last_of_run
//  cfg_*      | in  | tdata: total_count[15:0]
//
// Table write: the block stays idle; the next beat is taken on the following cycle.
// Encode: table reads and products (ST_RD0, ST_RD1, ST_MUL), two serial divisions
// (ST_DIV0, ST_DIV1), renormalization steps in ST_RENORM plus a closing check,
// and one result beat in ST_OUT per emitted bit. Flush: ST_FLUSH, then ST_OUT.
// Each result beat waits in ST_OUT until out_tready. Reset (rst_n, synchronous)
// restores state, interval, follow count, total and held bits; not the table.
`default_nettype none
`include "arith_encoder_static_32_unit_macros.svh"
module arith_encoder_static_32_unit #(
  parameter int ALPHABET_SIZE = 256,
  parameter int FREQ_BITS     = 16,
  parameter int CODE_BITS     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // operation
  input  wire logic [31:0] in_tdata,   // symbol[8:0], cum_entry[24:9]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // lead_bit[0], follow_count[32:1]
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_tdata   // total_count
);
  import aes32_pkg::*;

  localparam int DEPTH = ALPHABET_SIZE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = CODE_BITS + 1;
  localparam int PW    = RW + FREQ_BITS;
  localparam logic [CODE_BITS-1:0] FQ   = CODE_BITS'(1) << (CODE_BITS - 2);
  localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] TQ   = HALF + FQ;
  localparam int SCW = $clog2(CODE_BITS + 1);

  state_t state_r, state_nxt;
  logic [CODE_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CODE_BITS-1:0] nlo_r, hi_bound;
  logic [31:0]          pend_r, pend_nxt;
  logic [15:0]          total_r;
  logic [AW-1:0]        sym_r;
  logic [FREQ_BITS-1:0] c0_r, c1_r;
  logic [PW-1:0]        p0_r, p1_r;
  logic [RW-1:0]        range_r;
  logic [SCW-1:0]       step_r, step_nxt;
  logic                 obit_r, obit_nxt, have_r, have_nxt;
  logic [31:0]          ofol_r, ofol_nxt;
  logic                 ob_bit_r, ob_bit_nxt, ob_last_r, ob_last_nxt;
  logic [31:0]          ob_fol_r, ob_fol_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [FREQ_BITS-1:0] ram_rdata;
  logic                 div_start, div_done;
  logic [PW-1:0]        div_num, div_quot;
  logic [15:0]          tot_eff;
  logic                 in_fire;
  logic [8:0]           in_sym;
  logic [15:0]          in_cum;
  op_t                  in_op;
  logic                 ren_low, ren_up, ren_mid, ren_stop;
  logic [31:0]          pend_inc;
  logic [CODE_BITS-1:0] lo_sub, hi_sub;

  assign in_op    = op_t'(in_tuser);
  assign in_sym   = in_tdata[8:0];
  assign in_cum   = in_tdata[24:9];
  assign in_fire  = in_tvalid && in_tready;
  assign tot_eff  = (total_r == '0) ? 16'd1 : total_r;
  assign hi_bound = lo_r + CODE_BITS'(div_quot) - CODE_BITS'(1);

  // FSM outputs: handshakes, table port, divider control
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cfg_ready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    ram_we     = in_tvalid && (state_r == ST_IDLE) && in_op == OP_WRITE
                 && ({23'd0, in_sym} < DEPTH);
    ram_addr   = (state_r == ST_RD0) ? sym_r + 1'b1 : AW'(in_sym);
    div_start  = (state_r == ST_MUL) || (state_r == ST_DIV0 && div_done);
    div_num    = (state_r == ST_MUL) ? p0_r : p1_r;
  end

  // table memory: written by table beats, read at symbol and symbol+1
  aes32_ram #(.WIDTH(FREQ_BITS), .DEPTH(DEPTH)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(FREQ_BITS'(in_cum)),
    .rdata(ram_rdata)
  );

  aes32_div #(.NUM_W(PW), .DEN_W(16)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (tot_eff),
    .done (div_done),
    .quot (div_quot)
  );

  // renormalization step decisions
  always_comb begin
    pend_inc = (pend_r == 32'hFFFF_FFFF) ? pend_r : pend_r + 32'd1;
    ren_low  = hi_r < HALF;
    ren_up   = !ren_low && lo_r >= HALF;
    ren_mid  = !ren_low && !ren_up && lo_r >= FQ && hi_r < TQ;
    ren_stop = (!ren_low && !ren_up && !ren_mid) || step_r == SCW'(CODE_BITS);
    lo_sub   = ren_up ? lo_r - HALF : (ren_mid ? lo_r - FQ : lo_r);
    hi_sub   = ren_up ? hi_r - HALF : (ren_mid ? hi_r - FQ : hi_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_op == OP_ENCODE && {23'd0, in_sym} < ALPHABET_SIZE) begin
          state_nxt = ST_RD0;
        end else if (in_fire && in_op == OP_FLUSH) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV0;
      ST_DIV0: state_nxt = div_done ? ST_DIV1 : ST_DIV0;
      ST_DIV1: state_nxt = div_done ? ST_RENORM : ST_DIV1;
      ST_RENORM: begin
        if (ren_stop) begin
          state_nxt = have_r ? ST_OUT : ST_IDLE;
        end else if ((ren_low || ren_up) && have_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ob_last_r ? ST_IDLE : ST_RENORM;
        end
      end
      ST_FLUSH: state_nxt = ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath; a found bit is held until the next step shows whether it ends the run
  always_comb begin
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    pend_nxt    = pend_r;
    step_nxt    = step_r;
    obit_nxt    = obit_r;
    ofol_nxt    = ofol_r;
    have_nxt    = have_r;
    ob_bit_nxt  = ob_bit_r;
    ob_fol_nxt  = ob_fol_r;
    ob_last_nxt = ob_last_r;
    unique case (state_r)
      ST_DIV1: begin
        if (div_done) begin
          lo_nxt   = nlo_r;
          hi_nxt   = hi_bound;
          step_nxt = '0;
          have_nxt = 1'b0;
        end
      end
      ST_RENORM: begin
        // held bit goes to the output beat
        if (have_r && (ren_stop || ren_low || ren_up)) begin
          ob_bit_nxt  = obit_r;
          ob_fol_nxt  = ofol_r;
          ob_last_nxt = ren_stop;
          have_nxt    = 1'b0;
        end
        if (!ren_stop) begin
          if (ren_low || ren_up) begin
            obit_nxt = ren_up;
            ofol_nxt = pend_r;
            pend_nxt = '0;
            have_nxt = 1'b1;
          end else begin
            pend_nxt = pend_inc;
          end
          lo_nxt   = {lo_sub[CODE_BITS-2:0], 1'b0};
          hi_nxt   = {hi_sub[CODE_BITS-2:0], 1'b1};
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        ob_bit_nxt  = !(lo_r < FQ);
        ob_fol_nxt  = pend_inc;
        ob_last_nxt = 1'b1;
        pend_nxt    = '0;
        lo_nxt      = '0;
        hi_nxt      = '1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lo_r      <= '0;
      hi_r      <= '1;
      pend_r    <= '0;
      total_r   <= 16'd1;
      step_r    <= '0;
      obit_r    <= 1'b0;
      ofol_r    <= '0;
      have_r    <= 1'b0;
      ob_bit_r  <= 1'b0;
      ob_fol_r  <= '0;
      ob_last_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        total_r <= 16'(cfg_tdata[FREQ_BITS > 16 ? 15 : FREQ_BITS-1:0]);
      end
      state_r   <= state_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      pend_r    <= pend_nxt;
      step_r    <= step_nxt;
      obit_r    <= obit_nxt;
      ofol_r    <= ofol_nxt;
      have_r    <= have_nxt;
      ob_bit_r  <= ob_bit_nxt;
      ob_fol_r  <= ob_fol_nxt;
      ob_last_r <= ob_last_nxt;
    end
    if (in_fire) begin
      sym_r <= AW'(in_sym);
    end
    // low bound entry and range; range wraps at CODE_BITS+1 bits
    if (state_r == ST_RD0) begin
      c0_r    <= ram_rdata;
      range_r <= RW'(hi_r) - RW'(lo_r) + RW'(1);
    end
    // one product per cycle
    if (state_r == ST_RD1) begin
      c1_r <= ram_rdata;
      p0_r <= PW'(range_r) * PW'(c0_r);
    end
    if (state_r == ST_MUL) begin
      p1_r <= PW'(range_r) * PW'(c1_r);
    end
    if (state_r == ST_DIV0 && div_done) begin
      nlo_r <= lo_r + CODE_BITS'(div_quot);
    end
  end

  assign out_tdata = {7'd0, ob_fol_r, ob_bit_r};
  assign out_tlast = ob_last_r;

  `AE_ASSERT_IMP(a_busy_no_in, clk, rst_n, state_r != ST_IDLE, !in_tready)
  `AE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `AE_ASSERT_NEXT(a_flush_out, clk, rst_n, state_r == ST_FLUSH, state_r == ST_OUT)
  `AE_ASSERT_IMP(a_step_bound, clk, rst_n, state_r == ST_RENORM, step_r <= SCW'(CODE_BITS))
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the static-model 32-bit arithmetic encoder.
// Depends on aes32_pkg and the arith_encoder_static_32_unit RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes32_pkg::*;

  localparam int          TABLE_DEPTH = 257;
  localparam int          SETTLE      = 200;
  localparam int          MAX_CYCLES  = 1000000;
  localparam logic [63:0] CODE_MASK   = 64'hFFFF_FFFF;
  localparam logic [63:0] RANGE_MASK  = 64'h1_FFFF_FFFF;
  localparam logic [63:0] Q1_LIM      = 64'h4000_0000;
  localparam logic [63:0] HALF        = 64'h8000_0000;
  localparam logic [63:0] Q3_LIM      = 64'hC000_0000;

  typedef struct packed {
    logic        lead;
    logic [31:0] follow;
    logic        last;
  } code_bit_t;

  // Shadow of the encoder state; predicts emitted code bits per input beat
  class code_bit_predictor;
    logic [15:0] cum [TABLE_DEPTH];
    logic [15:0] total;
    logic [63:0] low, high;
    logic [31:0] follow;
    code_bit_t   expected_bits[$];
    int          errors;

    function new();
      total  = 16'd1;
      low    = 64'd0;
      high   = CODE_MASK;
      follow = 32'd0;
      errors = 0;
    endfunction

    function void bump();
      if (follow != 32'hFFFF_FFFF) follow++;
    endfunction

    function void push_bit(logic b);
      code_bit_t e;
      e.lead = b;
      e.follow = follow;
      e.last = 1'b0;
      expected_bits.push_back(e);
      follow = 32'd0;
    endfunction

    function void note_item(op_t op, logic [8:0] sym, logic [15:0] entry);
      logic [63:0] tot, rng, lo, hi, c0, c1;
      int n;
      n = 0;
      case (op)
        OP_WRITE: if (sym < TABLE_DEPTH) cum[sym] = entry;
        OP_ENCODE: begin
          if (sym < TABLE_DEPTH - 1) begin
            tot = (total == 16'd0) ? 64'd1 : {48'd0, total};
            c0  = {48'd0, cum[sym]};
            c1  = {48'd0, cum[sym + 1]};
            rng = (high - low + 64'd1) & RANGE_MASK;
            lo  = (low + (rng * c0) / tot) & CODE_MASK;
            hi  = (low + (rng * c1) / tot - 64'd1) & CODE_MASK;
            for (int s = 0; s < 32; s++) begin
              if (hi < HALF) begin
                push_bit(1'b0);
                n++;
              end else if (lo >= HALF) begin
                push_bit(1'b1);
                n++;
                lo -= HALF;
                hi -= HALF;
              end else if (lo >= Q1_LIM && hi < Q3_LIM) begin
                bump();
                lo -= Q1_LIM;
                hi -= Q1_LIM;
              end else begin
                break;
              end
              lo = (lo << 1) & CODE_MASK;
              hi = ((hi << 1) | 64'd1) & CODE_MASK;
            end
            low  = lo;
            high = hi;
            if (n > 0) expected_bits[$].last = 1'b1;
          end
        end
        OP_FLUSH: begin
          bump();
          push_bit(low < Q1_LIM ? 1'b0 : 1'b1);
          expected_bits[$].last = 1'b1;
          low    = 64'd0;
          high   = CODE_MASK;
          follow = 32'd0;
        end
        default: ;
      endcase
    endfunction

    function void check_bit(code_bit_t got);
      code_bit_t e;
      if (expected_bits.size() == 0) begin
        $display("%0t: unexpected code bit beat, actual %p", $realtime, got);
        errors++;
        return;
      end
      e = expected_bits.pop_front();
      if (got.lead !== e.lead) begin
        $display("%0t: lead_bit expected %0b actual %0b", $realtime, e.lead, got.lead);
        errors++;
      end
      if (got.follow !== e.follow) begin
        $display("%0t: follow_count expected %0d actual %0d", $realtime, e.follow,
                 got.follow);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $realtime, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = OP_NONE;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_tdata = '0;

  code_bit_predictor pred = new();
  bit          quiet = 1'b0;
  int          cycles = 0;
  int          stall_left = 0;
  logic [15:0] model_cum [TABLE_DEPTH];

  arith_encoder_static_32_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_tdata(cfg_tdata)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Result beat check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      pred.check_bit('{lead: out_tdata[0], follow: out_tdata[32:1], last: out_tlast});
  end

  // Table entries that get written; only symbols inside them are encoded
  function automatic bit in_window(int i);
    return (i <= 8) || (i >= 126 && i <= 130) || (i >= 250);
  endfunction

  // Any symbol whose two bounds are both written
  function automatic logic [8:0] window_symbol();
    int r;
    r = $urandom_range(0, 17);
    if (r < 8) return 9'(r);
    else if (r < 12) return 9'(126 + r - 8);
    else return 9'(250 + r - 12);
  endfunction

  // One input beat, with an optional idle burst in front
  task automatic send_item(op_t op, logic [8:0] sym, logic [15:0] entry);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {7'd0, entry, sym};
    do @(posedge clk); while (!in_tready);
    pred.note_item(op, sym, entry);
  endtask

  // Wait out every expected beat plus the tail of a silent encode
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pred.expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_total(logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_tdata = v;
    do @(posedge clk); while (!cfg_ready);
    pred.total = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Monotonic cumulative entries ending at the total; some symbols get no share
  task automatic load_table(logic [15:0] tot);
    int acc, stepmax;
    acc = 0;
    stepmax = tot / 24 + 1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (in_window(i)) begin
        if (i == TABLE_DEPTH - 1) acc = tot;
        else if (i > 0 && $urandom_range(0, 9) != 0) acc += $urandom_range(0, stepmax);
        if (acc > tot) acc = tot;
        model_cum[i] = acc[15:0];
        send_item(OP_WRITE, i[8:0], acc[15:0]);
      end
    end
  endtask

  function automatic logic [8:0] pick_symbol();
    logic [8:0] s;
    for (int k = 0; k < 20; k++) begin
      s = window_symbol();
      if (model_cum[s + 1] > model_cum[s]) return s;
    end
    return s;
  endfunction

  task automatic random_items(int count);
    int r, sent;
    logic [8:0] s;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        send_item(OP_ENCODE, pick_symbol(), 16'($urandom));
        sent++;
      end else if (r < 86) begin
        send_item(OP_FLUSH, 9'($urandom), 16'($urandom));
        sent++;
      end else if (r < 90) begin
        // broken model: overwrite one entry with noise
        do s = 9'($urandom_range(0, 256)); while (!in_window(s));
        model_cum[s] = 16'($urandom);
        send_item(OP_WRITE, s, model_cum[s]);
        sent++;
      end else if (r < 95) begin
        send_item(OP_ENCODE, window_symbol(), 16'($urandom));
        sent++;
      end else if (r < 97) begin
        send_item(OP_ENCODE, 9'($urandom_range(256, 511)), 16'($urandom));
      end else if (r < 98) begin
        send_item(OP_WRITE, 9'($urandom_range(257, 511)), 16'($urandom));
      end else begin
        send_item(OP_NONE, 9'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] totals [4];
    totals = '{16'd1, 16'd0, 16'd1000, 16'($urandom_range(2, 65534))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of every field and each special case
    write_total(16'hFFFF);
    load_table(16'hFFFF);
    send_item(OP_ENCODE, 9'd0, 16'hFFFF);
    send_item(OP_ENCODE, 9'd255, 16'h0000);
    send_item(OP_ENCODE, 9'd128, 16'h5555);
    send_item(OP_ENCODE, 9'd256, 16'hAAAA);
    send_item(OP_ENCODE, 9'd511, 16'hFFFF);
    send_item(OP_WRITE, 9'd511, 16'hFFFF);
    send_item(OP_WRITE, 9'd300, 16'h0000);
    send_item(OP_NONE, 9'd511, 16'hFFFF);
    send_item(OP_FLUSH, 9'd0, 16'h0000);
    send_item(OP_FLUSH, 9'd0, 16'h0000);
    for (int k = 0; k < 6; k++) send_item(OP_ENCODE, pick_symbol(), 16'h0);
    send_item(OP_FLUSH, 9'h1FF, 16'hFFFF);
    // Inverted interval from a non-monotonic pair
    send_item(OP_WRITE, 9'd5, 16'hF000);
    send_item(OP_ENCODE, 9'd5, 16'h0);
    send_item(OP_ENCODE, 9'd4, 16'h0);
    send_item(OP_WRITE, 9'd5, model_cum[5]);
    send_item(OP_FLUSH, 9'd0, 16'h0);

    // Random phases over several totals; the sender waits out each phase
    for (int p = 0; p < 4; p++) begin
      drain();
      if (p == 3) quiet = 1'b1;
      write_total(totals[p]);
      load_table(totals[p]);
      random_items(20);
      send_item(OP_FLUSH, 9'd0, 16'd0);
    end

    drain();
    if (pred.errors == 0 && pred.expected_bits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pred.expected_bits.size() != 0)
        $display("%0t: %0d expected code bits never arrived", $realtime,
                 pred.expected_bits.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
